/* hdl/gst_pkg.sv */
// Shared types, constants and codes of the gamepad state tracker.
package gst_pkg;

  localparam int unsigned NUM_PADS    = 8;
  localparam int unsigned NUM_BUTTONS = 32;
  localparam int unsigned NUM_AXES    = 8;

  localparam int unsigned NUM_ENT = NUM_PADS * NUM_AXES;
  localparam int unsigned PAD_IW  = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;
  localparam int unsigned BTN_IW  = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int unsigned AX_IW   = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int unsigned ENT_AW  = (NUM_ENT > 1) ? $clog2(NUM_ENT) : 1;

  // Axis scaling arithmetic: |v| and the deadzone are both held in units of 1/6553600.
  localparam int unsigned RAW_FULL  = 25600;    // 100 percent in Q8.8
  localparam int unsigned POS_ONE   = 6553600;  // 25600 * 256
  localparam int unsigned DZ_MAX    = 64880;    // 0.99 in Q0.16
  localparam int unsigned DZ_SCALE  = 100;
  localparam int unsigned ACC_W     = 23;       // holds POS_ONE
  localparam int unsigned MAG_W     = 15;       // holds RAW_FULL
  localparam int unsigned QF_W      = 15;       // quotient fraction bits
  localparam int unsigned CNT_W     = $clog2(QF_W);
  localparam int unsigned AXIS_W    = 16;
  localparam int unsigned AXIS_SAT  = 32767;

  typedef enum logic [2:0] {
    FN_CONNECT    = 3'd0,
    FN_DISCONNECT = 3'd1,
    FN_PRESS      = 3'd2,
    FN_RELEASE    = 3'd3,
    FN_AXIS_MOVE  = 3'd4,
    FN_END_FRAME  = 3'd5,
    FN_QUERY      = 3'd6
  } gst_func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PREP,
    ST_SETUP,
    ST_DIV,
    ST_WRITE,
    ST_READ,
    ST_LOAD
  } gst_state_e;

  typedef struct packed {
    logic [2:0]         func;
    logic [3:0]         pad_id;
    logic [5:0]         button_index;
    logic [3:0]         axis_index;
    logic signed [15:0] raw_position;
    logic [31:0]        initial_buttons;
  } gst_in_t;

  typedef struct packed {
    logic               is_connected;
    logic               button_level;
    logic               button_down;
    logic               button_up;
    logic signed [15:0] axis_value;
  } gst_out_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic prep;
    logic setup;
    logic div_step;
    logic write;
    logic read;
    logic load;
  } gst_cmd_t;

  typedef struct packed {
    logic axis_op;
    logic div_last;
    logic out_free;
  } gst_stat_t;

endpackage

/* hdl/gst_in_if.sv */
// Input channel of the gamepad state tracker: valid, ready and one input item.
interface gst_in_if;
  import gst_pkg::*;

  logic    valid;
  logic    ready;
  gst_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/gst_out_if.sv */
// Result channel of the gamepad state tracker: valid, ready and one result item.
interface gst_out_if;
  import gst_pkg::*;

  logic     valid;
  logic     ready;
  gst_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/gamepad_state_tracker.sv */
// Top level of the gamepad state tracker: controller, datapath and channel ports.
// Connect, disconnect, press, release, end frame and query beats pass through execution, an axis
// store read and the output load; axis move beats with a valid pad and axis also pass through
// the scaling preparation and setup, the 15-step restoring divider and an axis write before the read.
// One item is in work at a time; the output register lets the next beat enter while a result waits.
// Reset clears all pad state, the axis valid bits and the deadzone at once; no clearing pass.
module gamepad_state_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  gst_in_if.sink      in_i,
  gst_out_if.source   out_o
);
  import gst_pkg::*;

  // The controller sequences each beat through execution, optional axis scaling,
  // an axis store read and the load of the output register.
  gst_cmd_t  cmd;
  gst_stat_t stat;
  logic      in_ready;

  gst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // The datapath holds the per-pad flags and bitmaps in flip-flops and the scaled
  // axis values in a RAM whose entries read as zero after reset, a connect or a disconnect until written.
  gst_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_i.data),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

  assign in_i.ready = in_ready;

endmodule

/* hdl/gst_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module gst_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/gst_ctrl.sv */
// Controller state machine of the gamepad state tracker.
module gst_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  gst_pkg::gst_stat_t stat_i,
  output gst_pkg::gst_cmd_t  cmd_o
);
  import gst_pkg::*;

  gst_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC:  state_d = stat_i.axis_op ? ST_PREP : ST_READ;
      ST_PREP:  state_d = ST_SETUP;
      ST_SETUP: state_d = ST_DIV;
      ST_DIV:   if (stat_i.div_last) state_d = ST_WRITE;
      ST_WRITE: state_d = ST_READ;
      ST_READ:  state_d = ST_LOAD;
      ST_LOAD:  if (stat_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_EXEC:  cmd_o.exec     = 1'b1;
      ST_PREP:  cmd_o.prep     = 1'b1;
      ST_SETUP: cmd_o.setup    = 1'b1;
      ST_DIV:   cmd_o.div_step = 1'b1;
      ST_WRITE: cmd_o.write    = 1'b1;
      ST_READ:  cmd_o.read     = 1'b1;
      ST_LOAD:  cmd_o.load     = stat_i.out_free;
      default:  cmd_o          = '0;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_EXEC))
    else $error("accepted item did not move to execution");

  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> stat_i.out_free)
    else $error("result loaded while output register occupied");

  a_one_command: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command in a cycle");

  a_div_ends_in_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.div_step && stat_i.div_last) |=> cmd_o.write)
    else $error("division end not followed by axis write");
`endif

endmodule

/* hdl/gst_dp.sv */
// Datapath of the gamepad state tracker: pad registers, axis store and deadzone divider.
module gst_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  gst_pkg::gst_in_t   in_data_i,
  input  gst_pkg::gst_cmd_t  cmd_i,
  output gst_pkg::gst_stat_t stat_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gst_pkg::gst_out_t  out_data_o
);
  import gst_pkg::*;

  // Captured item.
  logic [2:0]  func_q;
  logic [3:0]  pad_q;
  logic [5:0]  btn_q;
  logic [3:0]  axis_q;
  logic [15:0] raw_q;
  logic [31:0] init_q;

  logic [15:0] dz_q;

  logic                   conn_q  [NUM_PADS];
  logic [NUM_BUTTONS-1:0] bnow_q  [NUM_PADS];
  logic [NUM_BUTTONS-1:0] bprev_q [NUM_PADS];
  logic [NUM_ENT-1:0]     vld_q;

  // Divider state.
  logic [ACC_W-1:0] a_q, d100_q, den_q, rem_q;
  logic [QF_W-1:0]  quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             below_q, sat_q;

  logic     out_valid_q;
  gst_out_t out_q;

  logic              pad_ok, btn_ok, ax_ok;
  logic [PAD_IW-1:0] pad_sel;
  logic [BTN_IW-1:0] btn_sel;
  logic [AX_IW-1:0]  ax_sel;
  logic [ENT_AW-1:0] ent_addr;
  gst_func_e         func;

  assign func     = gst_func_e'(func_q);
  assign pad_ok   = {1'b0, pad_q} < 5'(NUM_PADS);
  assign btn_ok   = btn_q < 6'(NUM_BUTTONS);
  assign ax_ok    = {1'b0, axis_q} < 5'(NUM_AXES);
  assign pad_sel  = pad_q[PAD_IW-1:0];
  assign btn_sel  = btn_q[BTN_IW-1:0];
  assign ax_sel   = axis_q[AX_IW-1:0];
  assign ent_addr = ENT_AW'(ENT_AW'(pad_sel) * ENT_AW'(NUM_AXES) + ENT_AW'(ax_sel));

  // Magnitude of the raw position, clamped to full scale.
  logic [15:0]      mag;
  logic [MAG_W-1:0] mag_c;
  logic [15:0]      dz_sat;

  assign mag    = raw_q[15] ? 16'(~raw_q + 16'd1) : raw_q;
  assign mag_c  = (mag > 16'(RAW_FULL)) ? MAG_W'(RAW_FULL) : mag[MAG_W-1:0];
  assign dz_sat = (dz_q > 16'(DZ_MAX)) ? 16'(DZ_MAX) : dz_q;

  // One restoring division step.
  logic [ACC_W+1:0] trial;
  logic             q_bit;

  assign trial = {1'b0, rem_q, 1'b0} - {2'b00, den_q};
  assign q_bit = !trial[ACC_W+1];

  // Final axis value.
  logic [QF_W-1:0]   res_mag;
  logic [AXIS_W-1:0] res_val;

  assign res_mag = below_q ? '0 : (sat_q ? QF_W'(AXIS_SAT) : quo_q);
  assign res_val = raw_q[15] ? AXIS_W'(-{1'b0, res_mag}) : {1'b0, res_mag};

  logic [AXIS_W-1:0] ram_rdata;

  gst_ram #(
    .WIDTH (AXIS_W),
    .DEPTH (NUM_ENT)
  ) u_axis_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write),
    .waddr_i (ent_addr),
    .wdata_i (res_val),
    .re_i    (cmd_i.read),
    .raddr_i (ent_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= in_data_i.func;
      pad_q  <= in_data_i.pad_id;
      btn_q  <= in_data_i.button_index;
      axis_q <= in_data_i.axis_index;
      raw_q  <= in_data_i.raw_position;
      init_q <= in_data_i.initial_buttons;
    end
    if (cmd_i.prep) begin
      a_q    <= {mag_c, 8'd0};
      d100_q <= ACC_W'(dz_sat * ACC_W'(DZ_SCALE));
    end
    if (cmd_i.setup) begin
      below_q <= a_q < d100_q;
      sat_q   <= (a_q - d100_q) >= (ACC_W'(POS_ONE) - d100_q);
      rem_q   <= a_q - d100_q;
      den_q   <= ACC_W'(POS_ONE) - d100_q;
      quo_q   <= '0;
      cnt_q   <= CNT_W'(QF_W - 1);
    end
    if (cmd_i.div_step) begin
      rem_q <= q_bit ? trial[ACC_W-1:0] : {rem_q[ACC_W-2:0], 1'b0};
      quo_q <= {quo_q[QF_W-2:0], q_bit};
      cnt_q <= cnt_q - CNT_W'(1);
    end
    if (cmd_i.load) begin
      out_q.is_connected <= pad_ok & conn_q[pad_sel];
      out_q.button_level <= pad_ok & btn_ok & bnow_q[pad_sel][btn_sel];
      out_q.button_down  <= pad_ok & btn_ok & bnow_q[pad_sel][btn_sel]
                            & ~bprev_q[pad_sel][btn_sel];
      out_q.button_up    <= pad_ok & btn_ok & bprev_q[pad_sel][btn_sel]
                            & ~bnow_q[pad_sel][btn_sel];
      out_q.axis_value   <= (pad_ok && ax_ok && vld_q[ent_addr]) ? $signed(ram_rdata)
                                                                 : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q  <= '0;
      vld_q <= '0;
      for (int p = 0; p < NUM_PADS; p++) begin
        conn_q[p]  <= 1'b0;
        bnow_q[p]  <= '0;
        bprev_q[p] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        dz_q <= cfg_wdata_i;
      end
      if (cmd_i.exec) begin
        if (func == FN_END_FRAME) begin
          for (int p = 0; p < NUM_PADS; p++) begin
            bprev_q[p] <= bnow_q[p];
          end
        end else if (pad_ok) begin
          unique case (func)
            FN_CONNECT: begin
              conn_q[pad_sel]  <= 1'b1;
              bnow_q[pad_sel]  <= init_q[NUM_BUTTONS-1:0];
              bprev_q[pad_sel] <= init_q[NUM_BUTTONS-1:0];
              for (int e = 0; e < NUM_ENT; e++) begin
                if (PAD_IW'(e / NUM_AXES) == pad_sel) vld_q[e] <= 1'b0;
              end
            end
            FN_DISCONNECT: begin
              conn_q[pad_sel]  <= 1'b0;
              bnow_q[pad_sel]  <= '0;
              bprev_q[pad_sel] <= '0;
              for (int e = 0; e < NUM_ENT; e++) begin
                if (PAD_IW'(e / NUM_AXES) == pad_sel) vld_q[e] <= 1'b0;
              end
            end
            FN_PRESS: begin
              if (btn_ok) begin
                conn_q[pad_sel]          <= 1'b1;
                bnow_q[pad_sel][btn_sel] <= 1'b1;
              end
            end
            FN_RELEASE: begin
              if (btn_ok) bnow_q[pad_sel][btn_sel] <= 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      if (cmd_i.write) begin
        vld_q[ent_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.axis_op  = (func == FN_AXIS_MOVE) && pad_ok && ax_ok;
  assign stat_o.div_last = (cnt_q == '0);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // Below the deadzone or at full scale the quotient is overridden, so the
  // remainder is only bounded when the division result is actually used.
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.div_step && !below_q && !sat_q) |-> (rem_q < den_q))
    else $error("divider remainder not below divisor");

  a_write_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write |=> vld_q[ent_addr])
    else $error("axis write left entry invalid");

  a_den_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (den_q >= ACC_W'(POS_ONE - DZ_MAX * DZ_SCALE)))
    else $error("divisor below the saturated-deadzone floor");
`endif

endmodule
